// File: design/dpcm_pkg.sv
// Shared types, constants and color tables for the depth pseudocolor map.
// No dependencies; every other design file imports this package.
`timescale 1ns / 1ps

package dpcm_pkg;

    // Fixed field widths
    localparam int SAMPLE_WIDTH = 16;
    localparam int COLOR_WIDTH  = 8;
    localparam int LOCAL_BITS   = 14;
    localparam int LOCAL_WIDTH  = LOCAL_BITS + 1;
    localparam int NUM_CHANNELS = 3;

    // Item opcodes
    typedef enum logic [1:0] {
        OP_CLEAR    = 2'd0,
        OP_MEASURE  = 2'd1,
        OP_COLORIZE = 2'd2
    } op_t;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_DIVIDE,
        ST_COLOR
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic stats_clear;
        logic stats_measure;
        logic sample_load;
        logic setup;
        logic div_step;
        logic color_load;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic div_needed;
        logic div_done;
        logic out_free;
    } status_t;

    typedef logic [NUM_CHANNELS-1:0][COLOR_WIDTH-1:0] rgb_t;

    // Segment base colors, channel 2 is red, 1 green, 0 blue
    function automatic rgb_t seg_base(input logic [1:0] seg);
        rgb_t res;
        case (seg)
            2'd0:    res = {8'd0,  8'd0,   8'd51};
            2'd1:    res = {8'd0,  8'd51,  8'd102};
            2'd2:    res = {8'd0,  8'd102, 8'd204};
            default: res = {8'd51, 8'd153, 8'd255};
        endcase
        return res;
    endfunction

    // Segment slopes over one quarter of the range
    function automatic rgb_t seg_slope(input logic [1:0] seg);
        rgb_t res;
        case (seg)
            2'd0:    res = {8'd0,   8'd51,  8'd51};
            2'd1:    res = {8'd0,   8'd51,  8'd102};
            2'd2:    res = {8'd51,  8'd51,  8'd51};
            default: res = {8'd153, 8'd102, 8'd0};
        endcase
        return res;
    endfunction

endpackage

// File: design/depth_pseudocolor_map_unit.sv
// Depth pseudocolor map: running min/max of depth samples and an RGB
// colormap normalized against that range.
// Usage:
//   Input channel (in_valid / in_stall, opcode, depth_sample) carries one
//   item per transfer. Clear and measure update the statistics and leave the
//   block ready; they give no result. Colorize gives one result item.
//   Output channel (out_valid / out_stall, red, green, blue, flat_range)
//   is driven from a register.
//   A colorize item runs from its transfer through setup, the restoring
//   divider that retires one quotient bit per cycle, and the output load
//   before the block is ready again; samples at or beyond the range bounds
//   or a flat range skip the divider and go from setup to the output load.
//   The result appears at the same edge that frees the input side.
//   While the receiver stalls, the result is held; the block still accepts
//   clear and measure items and runs the next colorize up to its output
//   load, where it waits for the output register to empty.
//   Reset clears the minimum to the largest and the maximum to the smallest
//   depth value, drops any pending result and returns to idle.
// Depends on dpcm_pkg, dpcm_ctrl and dpcm_datapath.
`timescale 1ns / 1ps

module depth_pseudocolor_map_unit #(
    parameter int DEPTH_BITS    = 16,
    parameter int FRACTION_BITS = 16
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      in_valid,
    output logic                                      in_stall,
    input  logic [1:0]                                opcode,
    input  logic signed [dpcm_pkg::SAMPLE_WIDTH-1:0]  depth_sample,
    output logic                                      out_valid,
    input  logic                                      out_stall,
    output logic [dpcm_pkg::COLOR_WIDTH-1:0]          red,
    output logic [dpcm_pkg::COLOR_WIDTH-1:0]          green,
    output logic [dpcm_pkg::COLOR_WIDTH-1:0]          blue,
    output logic                                      flat_range
);
    import dpcm_pkg::*;

    cmd_t    cmd;
    status_t status;

    dpcm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .opcode   (opcode),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    dpcm_datapath #(
        .DEPTH_BITS    (DEPTH_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .depth_sample (depth_sample),
        .cmd          (cmd),
        .status       (status),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .flat_range   (flat_range)
    );

`ifndef ASSERT_OFF
    // A colorize transfer makes the block busy
    a_colorize_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && opcode == OP_COLORIZE) |=> in_stall)
        else $error("block not busy after colorize transfer");

    // A flat range always maps to cyan
    a_flat_cyan: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && flat_range) |-> (red == 8'd204 && green == 8'd255
                                       && blue == 8'd255))
        else $error("flat range result is not cyan");

    // A new result only comes out of a busy block
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared without work in progress");

    // Clear and measure leave the block ready
    a_stats_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && (opcode == OP_CLEAR || opcode == OP_MEASURE))
        |=> !in_stall)
        else $error("statistics item did not complete in one cycle");
`endif

endmodule

// File: design/dpcm_ctrl.sv
// Controller state machine for the depth pseudocolor map.
// Depends on dpcm_pkg for state, opcode, command and status types.
`timescale 1ns / 1ps

module dpcm_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic [1:0]         opcode,
    output logic               in_stall,
    input  dpcm_pkg::status_t  status,
    output dpcm_pkg::cmd_t     cmd
);
    import dpcm_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Take items only when idle
    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;

    // Advance state and issue commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (opcode)
                        OP_CLEAR:    cmd.stats_clear   = 1'b1;
                        OP_MEASURE:  cmd.stats_measure = 1'b1;
                        OP_COLORIZE:
                        begin
                            cmd.sample_load = 1'b1;
                            state_next      = ST_SETUP;
                        end
                        default:     ; // drop the unused opcode
                    endcase
                end
            end
            ST_SETUP:
            begin
                cmd.setup  = 1'b1;
                state_next = status.div_needed ? ST_DIVIDE : ST_COLOR;
            end
            ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                if (status.div_done)
                begin
                    state_next = ST_COLOR;
                end
            end
            ST_COLOR:
            begin
                if (status.out_free)
                begin
                    cmd.color_load = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: design/dpcm_datapath.sv
// Datapath for the depth pseudocolor map: range statistics, restoring
// divider, segment color blend and output register. Depends on dpcm_pkg.
`timescale 1ns / 1ps

module dpcm_datapath #(
    parameter int DEPTH_BITS    = 16,
    parameter int FRACTION_BITS = 16
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic signed [dpcm_pkg::SAMPLE_WIDTH-1:0]  depth_sample,
    input  dpcm_pkg::cmd_t                            cmd,
    output dpcm_pkg::status_t                         status,
    output logic                                      out_valid,
    input  logic                                      out_stall,
    output logic [dpcm_pkg::COLOR_WIDTH-1:0]          red,
    output logic [dpcm_pkg::COLOR_WIDTH-1:0]          green,
    output logic [dpcm_pkg::COLOR_WIDTH-1:0]          blue,
    output logic                                      flat_range
);
    import dpcm_pkg::*;

    localparam int CNT_W = $clog2(FRACTION_BITS);
    localparam logic [CNT_W-1:0] CNT_INIT = CNT_W'(FRACTION_BITS - 1);
    localparam logic signed [DEPTH_BITS-1:0] DEPTH_MAX =
        {1'b0, {(DEPTH_BITS-1){1'b1}}};
    localparam logic signed [DEPTH_BITS-1:0] DEPTH_MIN =
        {1'b1, {(DEPTH_BITS-1){1'b0}}};
    localparam logic [FRACTION_BITS:0] T_FULL = {1'b1, {FRACTION_BITS{1'b0}}};

    // Sample wrapped to the working width
    logic signed [DEPTH_BITS+SAMPLE_WIDTH-1:0] sample_wide;
    logic signed [DEPTH_BITS-1:0]              sample_ext;

    logic signed [DEPTH_BITS-1:0] min_reg;
    logic signed [DEPTH_BITS-1:0] max_reg;
    logic signed [DEPTH_BITS-1:0] sample_reg;
    logic [DEPTH_BITS-1:0]        range_reg;
    logic [DEPTH_BITS-1:0]        rem_reg;
    logic [DEPTH_BITS-1:0]        rem_next;
    logic [FRACTION_BITS:0]       t_reg;
    logic [CNT_W-1:0]             cnt_reg;
    logic                         flat_reg;

    logic                         is_flat;
    logic                         ge_max;
    logic                         le_min;
    logic [DEPTH_BITS:0]          diff_full;
    logic [DEPTH_BITS:0]          range_full;
    logic [DEPTH_BITS:0]          rem_shift;
    logic [DEPTH_BITS:0]          rem_sub;
    logic                         q_bit;

    logic [1:0]                   seg;
    logic [FRACTION_BITS-2:0]     off;
    logic [FRACTION_BITS+14:0]    off_wide;
    logic [LOCAL_WIDTH-1:0]       local_frac;
    rgb_t                         base_rgb;
    rgb_t                         slope_rgb;
    rgb_t                         color;

    logic                         out_valid_reg;
    logic [COLOR_WIDTH-1:0]       red_reg;
    logic [COLOR_WIDTH-1:0]       green_reg;
    logic [COLOR_WIDTH-1:0]       blue_reg;
    logic                         flat_out_reg;

    assign sample_wide = {{DEPTH_BITS{depth_sample[SAMPLE_WIDTH-1]}}, depth_sample};
    assign sample_ext  = sample_wide[DEPTH_BITS-1:0];

    // Track running minimum and maximum
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg <= DEPTH_MAX;
            max_reg <= DEPTH_MIN;
        end
        else if (cmd.stats_clear)
        begin
            min_reg <= DEPTH_MAX;
            max_reg <= DEPTH_MIN;
        end
        else if (cmd.stats_measure)
        begin
            if (sample_ext < min_reg)
            begin
                min_reg <= sample_ext;
            end
            if (sample_ext > max_reg)
            begin
                max_reg <= sample_ext;
            end
        end
    end

    // Classify the sample against the range
    assign is_flat    = (max_reg <= min_reg);
    assign ge_max     = (sample_reg >= max_reg);
    assign le_min     = (sample_reg <= min_reg);
    assign diff_full  = {sample_reg[DEPTH_BITS-1], sample_reg}
                        - {min_reg[DEPTH_BITS-1], min_reg};
    assign range_full = {max_reg[DEPTH_BITS-1], max_reg}
                        - {min_reg[DEPTH_BITS-1], min_reg};

    assign status.div_needed = !(is_flat || ge_max || le_min);
    assign status.div_done   = (cnt_reg == '0);

    // One restoring step: shift remainder, try to subtract the range
    assign rem_shift = {rem_reg, 1'b0};
    assign rem_sub   = rem_shift - {1'b0, range_reg};
    assign q_bit     = (rem_shift >= {1'b0, range_reg});
    assign rem_next  = q_bit ? rem_sub[DEPTH_BITS-1:0] : rem_shift[DEPTH_BITS-1:0];

    // Sample capture, setup and divider registers
    always_ff @(posedge clk)
    begin
        if (cmd.sample_load)
        begin
            sample_reg <= sample_ext;
        end
        if (cmd.setup)
        begin
            flat_reg  <= is_flat;
            range_reg <= range_full[DEPTH_BITS-1:0];
            rem_reg   <= diff_full[DEPTH_BITS-1:0];
            cnt_reg   <= CNT_INIT;
            t_reg     <= (is_flat || ge_max) ? T_FULL : '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= rem_next;
            cnt_reg <= cnt_reg - 1'b1;
            t_reg   <= {t_reg[FRACTION_BITS-1:0], q_bit};
        end
    end

    // Pick segment and Q14 local fraction
    assign seg        = t_reg[FRACTION_BITS] ? 2'd3 : t_reg[FRACTION_BITS-1:FRACTION_BITS-2];
    assign off        = {t_reg[FRACTION_BITS], t_reg[FRACTION_BITS-3:0]};
    assign off_wide   = {off, 16'd0};
    assign local_frac = off_wide[FRACTION_BITS +: LOCAL_WIDTH];
    assign base_rgb   = seg_base(seg);
    assign slope_rgb  = seg_slope(seg);

    // Blend each channel and saturate
    always_comb
    begin
        logic [COLOR_WIDTH+LOCAL_WIDTH-1:0] prod;
        logic [COLOR_WIDTH+1:0]             sum;
        for (int ch = 0; ch < NUM_CHANNELS; ch++)
        begin
            prod = slope_rgb[ch] * local_frac;
            sum  = {2'b00, base_rgb[ch]}
                   + {1'b0, prod[COLOR_WIDTH+LOCAL_WIDTH-1:LOCAL_BITS]};
            color[ch] = (sum > 10'd255) ? 8'd255 : sum[COLOR_WIDTH-1:0];
        end
    end

    // Output valid: set on load, clear on transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.color_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (cmd.color_load)
        begin
            red_reg      <= color[2];
            green_reg    <= color[1];
            blue_reg     <= color[0];
            flat_out_reg <= flat_reg;
        end
    end

    assign status.out_free = !out_valid_reg || !out_stall;
    assign out_valid       = out_valid_reg;
    assign red             = red_reg;
    assign green           = green_reg;
    assign blue            = blue_reg;
    assign flat_range      = flat_out_reg;

endmodule
